[rtl/assert_macros.svh]
// Assertion macros shared by the encoder RTL.
// Self-contained; synthesis builds get empty bodies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Immediate-style property checked at every clock edge outside reset
`define LTSE_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) else $error(msg);
// Property whose consequent must hold in the clock cycle after the antecedent
`define LTSE_ASSERT_NEXT(lbl, clk, rst_n, pre, post, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (pre) |=> (post)) \
        else $error(msg);
`else
`define LTSE_ASSERT(lbl, clk, rst_n, prop, msg)
`define LTSE_ASSERT_NEXT(lbl, clk, rst_n, pre, post, msg)
`endif
`endif

[rtl/ltse_pkg.sv]
// Package for the line timestamp scramble encoder: widths, byte codes,
// key table, command/status structs and helper functions. No dependencies.
`timescale 1ns / 1ps

package ltse_pkg;

    // field widths
    localparam int BYTE_W      = 8;
    localparam int STAMP_W     = 24;

    // grouping and key
    localparam int GROUP_BYTES = 12;
    localparam int GROUP_W     = $clog2(GROUP_BYTES + 1);
    localparam int KEY_BYTES   = 50;
    localparam int KEY_W       = $clog2(KEY_BYTES);

    // decimal stamp: at most eight digits for a 24-bit value
    localparam int DIGITS      = 8;
    localparam int DIGIT_IDX_W = $clog2(DIGITS);
    localparam int DIGIT_CNT_W = $clog2(DIGITS + 1);

    // divide by ten: q = (v * DIV_MUL) >> DIV_SHIFT, exact for 24-bit v
    localparam logic [STAMP_W-1:0] DIV_MUL   = 24'hCCCCCD;
    localparam int                 DIV_SHIFT = 27;

    // byte codes
    localparam logic [BYTE_W-1:0] NEWLINE     = 8'h0A;
    localparam logic [BYTE_W-1:0] STAMP_OPEN  = 8'h18;
    localparam logic [BYTE_W-1:0] STAMP_CLOSE = 8'h19;
    localparam logic [BYTE_W-1:0] PAD_CHAR    = 8'h31;
    localparam logic [BYTE_W-1:0] TRAIL_FIRST = 8'h80;
    localparam logic [BYTE_W-1:0] TRAIL_LAST  = 8'h0A;
    localparam logic [BYTE_W-1:0] HIGH_BIT    = 8'h80;
    localparam logic [BYTE_W-1:0] BIAS        = 8'd32;
    localparam logic [3:0]        ASCII_DIGIT = 4'h3;

    // scramble key
    localparam logic [BYTE_W-1:0] KEY_TABLE [KEY_BYTES] = '{
        8'd84,  8'd105, 8'd109, 8'd101, 8'd115, 8'd116, 8'd97,  8'd109, 8'd112, 8'd32,
        8'd40,  8'd70,  8'd73,  8'd67,  8'd83,  8'd41,  8'd32,  8'd118, 8'd49,  8'd46,
        8'd48,  8'd32,  8'd45,  8'd32,  8'd112, 8'd114, 8'd111, 8'd103, 8'd114, 8'd97,
        8'd109, 8'd109, 8'd101, 8'd100, 8'd32,  8'd98,  8'd121, 8'd32,  8'd72,  8'd101,
        8'd110, 8'd114, 8'd105, 8'd107, 8'd32,  8'd71,  8'd114, 8'd97,  8'd109, 8'd46
    };

    // source of the byte pushed into the group
    typedef enum logic [2:0] {
        PUSH_INPUT,
        PUSH_OPEN,
        PUSH_DIGIT,
        PUSH_CLOSE,
        PUSH_PAD
    } t_push_sel;

    // kind of output beat
    typedef enum logic [1:0] {
        EMIT_GROUP,
        EMIT_TRAIL_FIRST,
        EMIT_TRAIL_LAST
    } t_emit_sel;

    // controller to datapath
    typedef struct packed {
        logic      push;
        t_push_sel push_sel;
        logic      emit;
        t_emit_sel emit_sel;
        logic      stamp_load;
        logic      div_q;
        logic      div_r;
        logic      key_clear;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic in_newline;
        logic group_last;
        logic flush_last;
        logic quot_zero;
        logic digits_last;
        logic digit_one;
        logic emit_ready;
    } t_status;

    // position inside a group read for output slot i (pairs 0/11, 2/9, 4/7 swapped)
    function automatic logic [GROUP_W-1:0] group_src(input logic [GROUP_W-1:0] i);
        logic [GROUP_W-1:0] s;
        case (i)
            4'd0:    s = 4'd11;
            4'd11:   s = 4'd0;
            4'd2:    s = 4'd9;
            4'd9:    s = 4'd2;
            4'd4:    s = 4'd7;
            4'd7:    s = 4'd4;
            default: s = i;
        endcase
        return s;
    endfunction

    // ((b | 0x80) ^ k) - 32, wrapping at eight bits
    function automatic logic [BYTE_W-1:0] scramble(input logic [BYTE_W-1:0] b,
                                                   input logic [BYTE_W-1:0] k);
        return ((b | HIGH_BIT) ^ k) - BIAS;
    endfunction

endpackage

[rtl/ltse_if.sv]
// Valid/ready channel interfaces for the encoder input and output beats.
// Depends on ltse_pkg for the payload widths.
`timescale 1ns / 1ps

interface ltse_in_if import ltse_pkg::*;;
    logic                valid;
    logic                ready;
    logic [BYTE_W-1:0]   in_byte;
    logic [STAMP_W-1:0]  stamp_ms;

    modport source (output valid, in_byte, stamp_ms, input ready);
    modport sink   (input valid, in_byte, stamp_ms, output ready);
endinterface

interface ltse_out_if import ltse_pkg::*;;
    logic                valid;
    logic                ready;
    logic [BYTE_W-1:0]   out_byte;
    logic                end_of_message;

    modport source (output valid, out_byte, end_of_message, input ready);
    modport sink   (input valid, out_byte, end_of_message, output ready);
endinterface

[rtl/ltse_datapath.sv]
// Datapath of the encoder: group buffer, digit stack, divide-by-ten unit,
// key counter and output register. Depends on ltse_pkg.
`timescale 1ns / 1ps

module ltse_datapath import ltse_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_cmd                i_cmd,
    output t_status             o_status,
    input  logic [BYTE_W-1:0]   i_in_byte,
    input  logic [STAMP_W-1:0]  i_stamp_ms,
    input  logic                i_out_ready,
    output logic                o_out_valid,
    output logic [BYTE_W-1:0]   o_out_byte,
    output logic                o_out_eom
);

    // group buffer and counters
    logic [BYTE_W-1:0]      r_group [GROUP_BYTES];
    logic [GROUP_W-1:0]     r_fill;
    logic [GROUP_W-1:0]     r_idx;
    logic [KEY_W-1:0]       r_key;

    // stamp conversion
    logic [STAMP_W-1:0]     r_val;
    logic [STAMP_W-1:0]     r_quot;
    logic [3:0]             r_digits [DIGITS];
    logic [DIGIT_CNT_W-1:0] r_ndig;

    // output register
    logic                   r_out_valid;
    logic [BYTE_W-1:0]      r_out_byte;
    logic                   r_out_eom;

    logic [2*STAMP_W-1:0]   w_prod;
    logic [STAMP_W-1:0]     w_quot;
    logic [STAMP_W-1:0]     w_ten_q;
    logic [STAMP_W-1:0]     w_rem;
    logic [DIGIT_CNT_W-1:0] w_ndig_dec;
    logic [BYTE_W-1:0]      w_push_byte;
    logic [BYTE_W-1:0]      w_emit_byte;
    logic                   w_emit_eom;
    logic [KEY_W-1:0]       w_key_next;

    // divide by ten: multiply by reciprocal, then remainder by shift-add
    assign w_prod  = r_val * DIV_MUL;
    assign w_quot  = STAMP_W'(w_prod >> DIV_SHIFT);
    assign w_ten_q = STAMP_W'({r_quot, 3'b000}) + STAMP_W'({r_quot, 1'b0});
    assign w_rem   = r_val - w_ten_q;

    assign w_ndig_dec = r_ndig - 1'b1;

    // byte entering the group
    always_comb begin
        case (i_cmd.push_sel)
            PUSH_INPUT: w_push_byte = i_in_byte;
            PUSH_OPEN:  w_push_byte = STAMP_OPEN;
            PUSH_DIGIT: w_push_byte = {ASCII_DIGIT, r_digits[w_ndig_dec[DIGIT_IDX_W-1:0]]};
            PUSH_CLOSE: w_push_byte = STAMP_CLOSE;
            PUSH_PAD:   w_push_byte = PAD_CHAR;
            default:    w_push_byte = PAD_CHAR;
        endcase
    end

    // byte leaving through the output register
    always_comb begin
        case (i_cmd.emit_sel)
            EMIT_GROUP: begin
                w_emit_byte = scramble(r_group[group_src(r_idx)], KEY_TABLE[r_key]);
                w_emit_eom  = 1'b0;
            end
            EMIT_TRAIL_FIRST: begin
                w_emit_byte = TRAIL_FIRST;
                w_emit_eom  = 1'b0;
            end
            EMIT_TRAIL_LAST: begin
                w_emit_byte = TRAIL_LAST;
                w_emit_eom  = 1'b1;
            end
            default: begin
                w_emit_byte = TRAIL_LAST;
                w_emit_eom  = 1'b0;
            end
        endcase
    end

    assign w_key_next = (r_key == KEY_W'(KEY_BYTES - 1)) ? '0 : r_key + 1'b1;

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill      <= '0;
            r_idx       <= '0;
            r_key       <= '0;
            r_ndig      <= '0;
            r_val       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.push) begin
                r_fill <= r_fill + 1'b1;
            end
            if (i_cmd.push && i_cmd.push_sel == PUSH_DIGIT) begin
                r_ndig <= w_ndig_dec;
            end
            if (i_cmd.stamp_load) begin
                r_val  <= i_stamp_ms;
                r_ndig <= '0;
            end
            if (i_cmd.div_r) begin
                r_val  <= r_quot;
                r_ndig <= r_ndig + 1'b1;
            end
            if (i_cmd.emit && i_cmd.emit_sel == EMIT_GROUP) begin
                r_key <= w_key_next;
                if (r_idx == GROUP_W'(GROUP_BYTES - 1)) begin
                    r_idx  <= '0;
                    r_fill <= '0;
                end else begin
                    r_idx <= r_idx + 1'b1;
                end
            end
            if (i_cmd.key_clear) begin
                r_key <= '0;
            end
            if (i_cmd.emit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.push) begin
            r_group[r_fill] <= w_push_byte;
        end
        if (i_cmd.div_q) begin
            r_quot <= w_quot;
        end
        if (i_cmd.div_r) begin
            r_digits[r_ndig[DIGIT_IDX_W-1:0]] <= w_rem[3:0];
        end
        if (i_cmd.emit) begin
            r_out_byte <= w_emit_byte;
            r_out_eom  <= w_emit_eom;
        end
    end

    // status to controller
    assign o_status.in_newline  = (i_in_byte == NEWLINE);
    assign o_status.group_last  = (r_fill == GROUP_W'(GROUP_BYTES - 1));
    assign o_status.flush_last  = (r_idx == GROUP_W'(GROUP_BYTES - 1));
    assign o_status.quot_zero   = (r_quot == '0);
    assign o_status.digits_last = (r_ndig == DIGIT_CNT_W'(DIGITS - 1));
    assign o_status.digit_one   = (r_ndig == DIGIT_CNT_W'(1));
    assign o_status.emit_ready  = !r_out_valid || i_out_ready;

    assign o_out_valid = r_out_valid;
    assign o_out_byte  = r_out_byte;
    assign o_out_eom   = r_out_eom;

endmodule

[rtl/ltse_ctrl.sv]
// Controller of the encoder: sequences byte intake, stamp conversion,
// message tail and group flushes. Depends on ltse_pkg.
`timescale 1ns / 1ps

module ltse_ctrl import ltse_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_ready,
    input  t_status i_status,
    output t_cmd    o_cmd
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_DIV_Q,
        S_DIV_R,
        S_OPEN,
        S_DIG,
        S_CLOSE,
        S_PAD,
        S_FLUSH,
        S_TRAIL1,
        S_TRAIL2
    } t_state;

    t_state r_state, n_state;
    t_state r_ret,   n_ret;
    t_state w_after_dig;

    // state and return point after a flush
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ret   <= S_IDLE;
        end else begin
            r_state <= n_state;
            r_ret   <= n_ret;
        end
    end

    assign w_after_dig = i_status.digit_one ? S_CLOSE : S_DIG;

    // next state and commands
    always_comb begin
        o_cmd          = '0;
        o_cmd.push_sel = PUSH_INPUT;
        o_cmd.emit_sel = EMIT_GROUP;
        n_state        = r_state;
        n_ret          = r_ret;
        o_in_ready     = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    if (i_status.in_newline) begin
                        o_cmd.stamp_load = 1'b1;
                        n_state          = S_DIV_Q;
                    end else begin
                        o_cmd.push = 1'b1;
                        if (i_status.group_last) begin
                            n_state = S_FLUSH;
                            n_ret   = S_IDLE;
                        end
                    end
                end
            end
            S_DIV_Q: begin
                o_cmd.div_q = 1'b1;
                n_state     = S_DIV_R;
            end
            S_DIV_R: begin
                o_cmd.div_r = 1'b1;
                n_state     = (i_status.quot_zero || i_status.digits_last) ? S_OPEN : S_DIV_Q;
            end
            S_OPEN: begin
                o_cmd.push     = 1'b1;
                o_cmd.push_sel = PUSH_OPEN;
                if (i_status.group_last) begin
                    n_state = S_FLUSH;
                    n_ret   = S_DIG;
                end else begin
                    n_state = S_DIG;
                end
            end
            S_DIG: begin
                o_cmd.push     = 1'b1;
                o_cmd.push_sel = PUSH_DIGIT;
                if (i_status.group_last) begin
                    n_state = S_FLUSH;
                    n_ret   = w_after_dig;
                end else begin
                    n_state = w_after_dig;
                end
            end
            S_CLOSE: begin
                o_cmd.push     = 1'b1;
                o_cmd.push_sel = PUSH_CLOSE;
                if (i_status.group_last) begin
                    n_state = S_FLUSH;
                    n_ret   = S_TRAIL1;
                end else begin
                    n_state = S_PAD;
                end
            end
            S_PAD: begin
                o_cmd.push     = 1'b1;
                o_cmd.push_sel = PUSH_PAD;
                if (i_status.group_last) begin
                    n_state = S_FLUSH;
                    n_ret   = S_TRAIL1;
                end
            end
            S_FLUSH: begin
                if (i_status.emit_ready) begin
                    o_cmd.emit = 1'b1;
                    if (i_status.flush_last) begin
                        n_state = r_ret;
                    end
                end
            end
            S_TRAIL1: begin
                if (i_status.emit_ready) begin
                    o_cmd.emit     = 1'b1;
                    o_cmd.emit_sel = EMIT_TRAIL_FIRST;
                    n_state        = S_TRAIL2;
                end
            end
            S_TRAIL2: begin
                if (i_status.emit_ready) begin
                    o_cmd.emit      = 1'b1;
                    o_cmd.emit_sel  = EMIT_TRAIL_LAST;
                    o_cmd.key_clear = 1'b1;
                    n_state         = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

[rtl/line_timestamp_scramble_encoder_top.sv]
// Top level of the line timestamp scramble encoder.
// Depends on ltse_pkg, ltse_if, ltse_ctrl, ltse_datapath and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

// Encodes a text stream line by line. Each text byte is taken in the idle
// state and stored in a twelve-byte group; the byte that completes a group
// starts a flush of twelve output beats, one per cycle while the sink keeps
// up, during which no input is taken. A newline (dropped from the output)
// starts the message tail: the stamp is converted to decimal by a shared
// divide-by-ten unit, each digit taking a quotient step and then a remainder
// step, then the stamp marker, the digits, the closing marker and the pad
// bytes go into the group at one per cycle between flushes, each completed
// group flushing as above, and the two unscrambled trailer beats end the
// message, the last one flagged end_of_message. The output is registered, so
// a byte can be accepted while the last result still waits to be taken.
module line_timestamp_scramble_encoder_top import ltse_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    ltse_in_if.sink     i_in,
    ltse_out_if.source  o_out
);

    t_cmd    w_cmd;
    t_status w_status;

    // sequencing
    ltse_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (i_in.ready),
        .i_status   (w_status),
        .o_cmd      (w_cmd)
    );

    // storage, conversion and output register
    ltse_datapath u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .o_status    (w_status),
        .i_in_byte   (i_in.in_byte),
        .i_stamp_ms  (i_in.stamp_ms),
        .i_out_ready (o_out.ready),
        .o_out_valid (o_out.valid),
        .o_out_byte  (o_out.out_byte),
        .o_out_eom   (o_out.end_of_message)
    );

    // checks
    `LTSE_ASSERT(a_emit_room, i_clk, i_rst_n, !w_cmd.emit || w_status.emit_ready, "emit without room in output register")
    `LTSE_ASSERT(a_idle_no_emit, i_clk, i_rst_n, !(i_in.ready && w_cmd.emit), "output beat issued while taking input")
    `LTSE_ASSERT(a_eom_byte, i_clk, i_rst_n, !(o_out.valid && o_out.end_of_message) || (o_out.out_byte == TRAIL_LAST), "end of message on wrong byte")
    `LTSE_ASSERT_NEXT(a_eom_idle, i_clk, i_rst_n, w_cmd.emit && (w_cmd.emit_sel == EMIT_TRAIL_LAST), i_in.ready, "not ready after message end")

endmodule

[tb/tb.sv]
// Self-checking bench for the line timestamp scramble encoder: directed rows,
// then random text lines under four handshake phases. Needs ltse_pkg, ltse_if
// and the encoder RTL.
`timescale 1ns / 1ps

module tb;
    import ltse_pkg::*;

    localparam int          TAIL_CYCLES = 40;
    localparam int          PHASE_ITEMS = 95;
    localparam longint      TIMEOUT_NS  = 64'd20_000_000;
    localparam logic [7:0]  ASCII_ZERO  = 8'h30;

    // one output beat as the encoder should present it
    typedef struct packed {
        logic [BYTE_W-1:0] data;
        logic              eom;
    } t_enc_beat;

    // how a directed row is checked
    typedef enum logic [1:0] {
        ROW_PRED,       // expected beats come from the predictor
        ROW_QUIET,      // ordinary byte mid-group: no beat at all
        ROW_ZERO_LINE   // empty line, stamp 0, group empty: fixed message
    } t_row_kind;

    typedef struct packed {
        logic [BYTE_W-1:0]  text;
        logic [STAMP_W-1:0] stamp;
        t_row_kind          kind;
    } t_dir_row;

    // empty line with stamp 0: 18 '0' 19 then nine '1', swapped and keyed
    localparam logic [7:0] ZERO_LINE_BYTES [GROUP_BYTES] = '{
        8'hC5, 8'hB9, 8'hBC, 8'hB4, 8'hA2, 8'hA5,
        8'hB0, 8'hBC, 8'hA1, 8'h99, 8'h79, 8'hBE
    };

    localparam int N_DIR = 23;
    localparam t_dir_row DIR_ROWS [N_DIR] = '{
        '{8'h0A, 24'd0,        ROW_ZERO_LINE},  // first message after reset
        '{8'h00, 24'hFFFFFF,   ROW_QUIET},      // stamp ignored on text bytes
        '{8'hFF, 24'd0,        ROW_QUIET},
        '{8'h18, 24'd0,        ROW_QUIET},      // marker values as plain text
        '{8'h19, 24'd0,        ROW_QUIET},
        '{8'h80, 24'd0,        ROW_QUIET},
        '{8'h7F, 24'd0,        ROW_QUIET},
        '{8'h01, 24'd0,        ROW_QUIET},
        '{8'h55, 24'd0,        ROW_QUIET},
        '{8'hAA, 24'd0,        ROW_QUIET},
        '{8'h0B, 24'd0,        ROW_QUIET},
        '{8'h09, 24'd0,        ROW_QUIET},
        '{8'h31, 24'd0,        ROW_PRED},       // twelfth byte flushes a group
        '{8'h0A, 24'd9999999,  ROW_PRED},       // empty line, largest legal stamp
        '{8'h0A, 24'd0,        ROW_ZERO_LINE},
        '{8'h0A, 24'hFFFFFF,   ROW_PRED},       // stamp above range, 8 digits
        '{8'h41, 24'd0,        ROW_QUIET},
        '{8'h0A, 24'd9,        ROW_PRED},
        '{8'h0A, 24'd10,       ROW_PRED},
        '{8'h20, 24'd0,        ROW_PRED},
        '{8'h7E, 24'd0,        ROW_PRED},
        '{8'h0A, 24'd1234567,  ROW_PRED},       // tail fills group to 11, one pad
        '{8'h0A, 24'd99,       ROW_PRED}
    };

    logic i_clk = 1'b0;
    logic i_rst_n;

    ltse_in_if  in_ch ();
    ltse_out_if out_ch ();

    line_timestamp_scramble_encoder_top dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    // predictor state
    logic [BYTE_W-1:0] grp_bytes [GROUP_BYTES];
    int                grp_fill = 0;
    int                key_idx  = 0;

    t_enc_beat predicted_beats [$];
    t_enc_beat expected_beats [$];

    int src_idle_pct   = 0;
    int sink_stall_pct = 0;
    int errors         = 0;
    int items_sent     = 0;
    int beats_seen     = 0;
    int msgs_seen      = 0;

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    task automatic report_mismatch(input string msg);
        $display("MISMATCH at %0t: %s", $time, msg);
        errors++;
    endtask

    // add one byte to the group; a full group goes out swapped and keyed
    function automatic void load_group_byte(input logic [BYTE_W-1:0] b);
        t_enc_beat         r;
        logic [BYTE_W-1:0] src;
        int                j;
        grp_bytes[grp_fill] = b;
        grp_fill++;
        if (grp_fill == GROUP_BYTES) begin
            for (int i = 0; i < GROUP_BYTES; i++) begin
                // pairs 0/11, 2/9, 4/7 trade places
                j = ((i < 6) == (i % 2 == 0)) ? GROUP_BYTES - 1 - i : i;
                src = grp_bytes[j];
                r.data = ((src | HIGH_BIT) ^ KEY_TABLE[key_idx]) - BIAS;
                r.eom = 1'b0;
                predicted_beats.push_back(r);
                key_idx = (key_idx + 1) % KEY_BYTES;
            end
            grp_fill = 0;
        end
    endfunction

    // expected beats for one accepted input byte
    function automatic void predict_encoding(input logic [BYTE_W-1:0] b,
                                             input logic [STAMP_W-1:0] stamp);
        int digs [DIGITS];
        int nd;
        int v;
        if (b != NEWLINE) begin
            load_group_byte(b);
            return;
        end
        load_group_byte(STAMP_OPEN);
        v = stamp;
        nd = 0;
        do begin
            digs[nd] = v % 10;
            nd++;
            v = v / 10;
        end while (v != 0);
        for (int i = nd - 1; i >= 0; i--)
            load_group_byte(BYTE_W'(ASCII_ZERO + digs[i]));
        load_group_byte(STAMP_CLOSE);
        while (grp_fill != 0)
            load_group_byte(PAD_CHAR);
        predicted_beats.push_back(t_enc_beat'{TRAIL_FIRST, 1'b0});
        predicted_beats.push_back(t_enc_beat'{TRAIL_LAST, 1'b1});
        key_idx = 0;
    endfunction

    // queue what an accepted byte should produce
    task automatic book_item(input logic [BYTE_W-1:0] b, input logic [STAMP_W-1:0] stamp,
                             input t_row_kind kind);
        predict_encoding(b, stamp);
        case (kind)
            ROW_PRED: begin
                foreach (predicted_beats[i]) expected_beats.push_back(predicted_beats[i]);
            end
            ROW_ZERO_LINE: begin
                foreach (ZERO_LINE_BYTES[i])
                    expected_beats.push_back(t_enc_beat'{ZERO_LINE_BYTES[i], 1'b0});
                expected_beats.push_back(t_enc_beat'{TRAIL_FIRST, 1'b0});
                expected_beats.push_back(t_enc_beat'{TRAIL_LAST, 1'b1});
            end
            default: ;  // quiet row: nothing expected
        endcase
        predicted_beats.delete();
    endtask

    // drive one beat, with random idle cycles ahead of it
    task automatic send_beat(input logic [BYTE_W-1:0] b, input logic [STAMP_W-1:0] stamp,
                             input t_row_kind kind);
        while ($urandom_range(99) < src_idle_pct) begin
            in_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_ch.valid    <= 1'b1;
        in_ch.in_byte  <= b;
        in_ch.stamp_ms <= stamp;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        book_item(b, stamp, kind);
        items_sent++;
    endtask

    // hold the input off until every expected beat has come out
    task automatic drain();
        in_ch.valid <= 1'b0;
        while (expected_beats.size() != 0) @(posedge i_clk);
    endtask

    // one text line of random length and content, closed by a newline
    task automatic send_random_line();
        int                pick;
        int                len;
        logic [BYTE_W-1:0] b;
        logic [STAMP_W-1:0] stamp;
        pick = $urandom_range(99);
        if (pick < 75)      len = $urandom_range(14);
        else if (pick < 95) len = $urandom_range(40, 15);
        else                len = $urandom_range(80, 41);
        for (int i = 0; i < len; i++) begin
            if ($urandom_range(19) == 0) begin
                case ($urandom_range(4))
                    0:       b = STAMP_OPEN;
                    1:       b = STAMP_CLOSE;
                    2:       b = TRAIL_FIRST;
                    3:       b = 8'h00;
                    default: b = 8'hFF;
                endcase
            end else begin
                b = BYTE_W'($urandom_range(255));
                if (b == NEWLINE) b = 8'h0B;
            end
            send_beat(b, STAMP_W'($urandom), ROW_PRED);
        end
        pick = $urandom_range(9);
        if (pick < 7)      stamp = STAMP_W'($urandom_range(9999999));
        else if (pick < 8) stamp = STAMP_W'($urandom_range(99));
        else               stamp = STAMP_W'($urandom_range(24'hFFFFFF));
        send_beat(NEWLINE, stamp, ROW_PRED);
    endtask

    // receiver: random stall per cycle
    always @(posedge i_clk) begin
        out_ch.ready <= ($urandom_range(99) >= sink_stall_pct);
    end

    // output check against the oldest expected beat
    always @(posedge i_clk) begin : out_check
        t_enc_beat want;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            beats_seen++;
            if (out_ch.end_of_message) msgs_seen++;
            if (expected_beats.size() == 0) begin
                report_mismatch($sformatf("unexpected beat %02h eom %0b",
                                          out_ch.out_byte, out_ch.end_of_message));
            end else begin
                want = expected_beats.pop_front();
                if (out_ch.out_byte !== want.data)
                    report_mismatch($sformatf("beat %0d: out_byte %02h, want %02h",
                                              beats_seen, out_ch.out_byte, want.data));
                if (out_ch.end_of_message !== want.eom)
                    report_mismatch($sformatf("beat %0d: end_of_message %0b, want %0b",
                                              beats_seen, out_ch.end_of_message, want.eom));
            end
        end
    end

    // stimulus and end of run
    initial begin
        i_rst_n        <= 1'b0;
        in_ch.valid    <= 1'b0;
        in_ch.in_byte  <= '0;
        in_ch.stamp_ms <= '0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed rows
        src_idle_pct   = 30;
        sink_stall_pct = 30;
        foreach (DIR_ROWS[r])
            send_beat(DIR_ROWS[r].text, DIR_ROWS[r].stamp, DIR_ROWS[r].kind);
        drain();

        // random lines: free run, slow sender, slow receiver, both
        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0:       begin src_idle_pct = 0;  sink_stall_pct = 0;  end
                1:       begin src_idle_pct = 78; sink_stall_pct = 0;  end
                2:       begin src_idle_pct = 0;  sink_stall_pct = 78; end
                default: begin src_idle_pct = 30; sink_stall_pct = 30; end
            endcase
            begin : phase_run
                int goal;
                goal = items_sent + PHASE_ITEMS;
                while (items_sent < goal) send_random_line();
            end
            drain();
        end

        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (expected_beats.size() != 0)
            report_mismatch($sformatf("%0d expected beats never came",
                                      expected_beats.size()));

        $display("Sent %0d text beats; checked %0d encoded beats in %0d messages",
                 items_sent, beats_seen, msgs_seen);
        $display("Phases: directed rows, then free run, slow sender, slow receiver, both");
        if (errors == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    // watchdog
    initial begin
        #(TIMEOUT_NS);
        $display("Timeout with %0d beats still expected", expected_beats.size());
        $display("== FAIL ==");
        $finish;
    end

endmodule

[line_timestamp_scramble_encoder_top.f]
+incdir+rtl
rtl/ltse_pkg.sv
rtl/ltse_if.sv
rtl/ltse_datapath.sv
rtl/ltse_ctrl.sv
rtl/line_timestamp_scramble_encoder_top.sv
tb/tb.sv
